>>> hw/rtl/sacr_pkg.sv
// Shared constants, types and helper functions of the set-associative tag store.
package sacr_pkg;

	// Geometry
	localparam int NUM_SETS     = 16384;
	localparam int NUM_WAYS     = 4;
	localparam int ADDRESS_BITS = 32;

	localparam int OFFSET_BITS = 2;
	localparam int INDEX_W     = $clog2(NUM_SETS);
	localparam int TAG_LSB     = OFFSET_BITS + INDEX_W;
	localparam int TAG_RAW     = ADDRESS_BITS - TAG_LSB;
	localparam int TAG_W       = (TAG_RAW > 0) ? TAG_RAW : 1;
	localparam int WAY_W       = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int WAY_OUT_W   = 2;
	localparam int COUNT_W     = 32;
	localparam int LFSR_W      = 16;
	localparam int SEED_W      = 16;

	// Set index taken straight from the address bits, or reduced by reciprocal multiply
	localparam bit SETS_POW2 = (NUM_SETS == (1 << INDEX_W));
	localparam int QW        = ADDRESS_BITS - OFFSET_BITS;
	localparam int MOD_SH    = QW + INDEX_W;

	// Floor reciprocal of the set count; quotient low by at most one
	localparam logic [QW:0] MOD_RECIP = (QW + 1)'((64'd1 << MOD_SH) / NUM_SETS);

	localparam logic [LFSR_W-1:0]  LFSR_TAPS = 16'hB400;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Reciprocal for the victim way reduction
	localparam logic [32:0] WAY_RECIP = 33'((64'd1 << 32) / NUM_WAYS);

	typedef enum logic {
		CMD_ACCESS = 1'b0,
		CMD_CLEAR  = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_MOD,
		ST_READ,
		ST_LOOKUP
	} state_t;

	// One set as held in memory
	typedef struct packed {
		logic [NUM_WAYS-1:0][TAG_W-1:0] tags;
		logic [NUM_WAYS-1:0]            valid;
	} set_row_t;

	localparam int ROW_W = $bits(set_row_t);

	typedef struct packed {
		logic             hit;
		logic             evicted;
		logic [WAY_W-1:0] way;
	} lookup_t;

	// Galois LFSR, one step
	function automatic logic [LFSR_W-1:0] lfsr_step(logic [LFSR_W-1:0] s);
		logic [LFSR_W-1:0] o;
		o = s >> 1;
		if (s[0]) begin
			o = o ^ LFSR_TAPS;
		end
		return o;
	endfunction

	// x modulo NUM_WAYS by reciprocal multiply and one correction
	function automatic logic [WAY_W-1:0] victim_of(logic [LFSR_W-1:0] x);
		logic [48:0] prod;
		logic [16:0] quo;
		logic [16:0] rem;
		prod = {33'd0, x} * {16'd0, WAY_RECIP};
		quo  = prod[48:32];
		rem  = {1'b0, x} - 17'(quo * 17'(NUM_WAYS));
		if (rem >= 17'(NUM_WAYS)) begin
			rem = rem - 17'(NUM_WAYS);
		end
		return WAY_W'(rem);
	endfunction

endpackage

>>> hw/rtl/sacr_ram.sv
// Generic single-port synchronous RAM with registered read data.
module sacr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> hw/rtl/sacr_way_select.sv
// Tag compare, fill and victim choice, and the updated set row.
module sacr_way_select (
	input  sacr_pkg::set_row_t               row,
	input  logic [sacr_pkg::TAG_W-1:0]       tag,
	input  logic [sacr_pkg::WAY_W-1:0]       victim,
	output sacr_pkg::lookup_t                look,
	output sacr_pkg::set_row_t               new_row
);
	import sacr_pkg::*;

	logic             hit;
	logic [WAY_W-1:0] hit_way;
	logic             free;
	logic [WAY_W-1:0] free_way;
	logic [WAY_W-1:0] sel_way;

	// Lowest matching way and lowest empty way
	always_comb begin
		hit      = 1'b0;
		hit_way  = '0;
		free     = 1'b0;
		free_way = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (row.valid[w] && row.tags[w] == tag) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!row.valid[w]) begin
				free     = 1'b1;
				free_way = WAY_W'(w);
			end
		end
	end

	// Hit, else fill, else replace
	always_comb begin
		if (hit) begin
			sel_way = hit_way;
		end else if (free) begin
			sel_way = free_way;
		end else begin
			sel_way = victim;
		end
		look.hit     = hit;
		look.evicted = !hit && !free;
		look.way     = sel_way;
	end

	// Row written back on a miss
	always_comb begin
		new_row                = row;
		new_row.tags[sel_way]  = tag;
		new_row.valid[sel_way] = 1'b1;
	end

endmodule

>>> hw/rtl/set_assoc_cache_random_replace_unit.sv
// Top level: 4-way set-associative tag store with random replacement and hit/miss counters.
// An access reads the set from the synchronous memory, then compares and writes back;
// a set count that is not a power of two adds the MOD and READ states to reduce the index.
// Words wait for busy to fall; done rises for one cycle as busy falls; no receiver stall.
// A clear answers the next cycle, then zeroes all NUM_SETS (16384) set memory words.
// After reset the same sweep runs with busy high; configuration writes are taken at any time.
module set_assoc_cache_random_replace_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                command,
	input  logic [sacr_pkg::ADDRESS_BITS-1:0]   address,
	output logic                                done,
	output logic                                hit,
	output logic [sacr_pkg::WAY_OUT_W-1:0]      way,
	output logic                                evicted,
	output logic [sacr_pkg::COUNT_W-1:0]        hit_total,
	output logic [sacr_pkg::COUNT_W-1:0]        miss_total,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sacr_pkg::SEED_W-1:0]         cfg_data
);
	import sacr_pkg::*;

	state_t state_q, state_d;

	logic [INDEX_W-1:0] sweep_cnt_q;
	logic [INDEX_W-1:0] set_q;
	logic [TAG_W-1:0]   tag_q;
	logic [QW-1:0]      mod_x_q;
	logic [QW-1:0]      quo_q;
	logic [2*QW:0]      mod_prod;
	logic [QW-1:0]      quo_nxt;
	logic [QW-1:0]      mod_rem;
	logic [INDEX_W-1:0] set_red;

	logic [SEED_W-1:0]  seed_q;
	logic [LFSR_W-1:0]  lfsr_q;
	logic [LFSR_W-1:0]  lfsr_cand;
	logic [WAY_W-1:0]   victim_q;

	logic [COUNT_W-1:0] hit_cnt_q;
	logic [COUNT_W-1:0] miss_cnt_q;

	logic               done_q;
	logic               hit_q;
	logic [WAY_W-1:0]   way_q;
	logic               evicted_q;

	logic               accept;
	logic               sweep_last;
	logic               ram_we;
	logic [INDEX_W-1:0] ram_addr;
	set_row_t           ram_wdata;
	set_row_t           ram_rdata;
	lookup_t            look;
	set_row_t           new_row;

	assign accept     = start && !busy;
	assign busy       = (state_q != ST_IDLE);
	assign sweep_last = (sweep_cnt_q == INDEX_W'(NUM_SETS - 1));
	assign cfg_ready  = 1'b1;

	assign done       = done_q;
	assign hit        = hit_q;
	assign way        = WAY_OUT_W'(way_q);
	assign evicted    = evicted_q;
	assign hit_total  = hit_cnt_q;
	assign miss_total = miss_cnt_q;

	// Set memory: valid bits and tags of one set per word
	sacr_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NUM_SETS)
	) u_set_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	sacr_way_select u_way_select (
		.row    (ram_rdata),
		.tag    (tag_q),
		.victim (victim_q),
		.look   (look),
		.new_row(new_row)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_SWEEP: begin
				if (sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (command == CMD_CLEAR) begin
						state_d = ST_SWEEP;
					end else if (SETS_POW2) begin
						state_d = ST_LOOKUP;
					end else begin
						state_d = ST_MOD;
					end
				end
			end
			ST_MOD:    state_d = ST_READ;
			ST_READ:   state_d = ST_LOOKUP;
			ST_LOOKUP: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = set_q;
		ram_wdata = new_row;
		case (state_q)
			ST_SWEEP: begin
				ram_we    = 1'b1;
				ram_addr  = sweep_cnt_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				ram_addr = address[OFFSET_BITS +: INDEX_W];
			end
			ST_READ: begin
				ram_addr = set_red;
			end
			ST_LOOKUP: begin
				ram_we = !look.hit;
			end
			default: begin
				ram_addr = set_q;
			end
		endcase
	end

	// Set reduction: quotient estimate by reciprocal multiply
	always_comb begin
		mod_prod = (2*QW + 1)'(mod_x_q) * (2*QW + 1)'(MOD_RECIP);
		quo_nxt  = QW'(mod_prod >> MOD_SH);
	end

	// Remainder with one correction
	always_comb begin
		mod_rem = mod_x_q - QW'(quo_q * QW'(NUM_SETS));
		if (mod_rem >= QW'(NUM_SETS)) begin
			mod_rem = mod_rem - QW'(NUM_SETS);
		end
		set_red = INDEX_W'(mod_rem);
	end

	assign lfsr_cand = lfsr_step(lfsr_q);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			sweep_cnt_q <= '0;
			seed_q      <= SEED_W'(1);
			lfsr_q      <= LFSR_W'(1);
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				seed_q <= cfg_data;
			end
			if (state_q == ST_SWEEP) begin
				sweep_cnt_q <= sweep_cnt_q + INDEX_W'(1);
			end
			if (accept && command == CMD_CLEAR) begin
				sweep_cnt_q <= '0;
				hit_cnt_q   <= '0;
				miss_cnt_q  <= '0;
				lfsr_q      <= (seed_q == '0) ? LFSR_W'(1) : seed_q;
				done_q      <= 1'b1;
			end
			if (state_q == ST_LOOKUP) begin
				done_q <= 1'b1;
				if (look.hit) begin
					if (hit_cnt_q != COUNT_MAX) begin
						hit_cnt_q <= hit_cnt_q + COUNT_W'(1);
					end
				end else if (miss_cnt_q != COUNT_MAX) begin
					miss_cnt_q <= miss_cnt_q + COUNT_W'(1);
				end
				if (look.evicted) begin
					lfsr_q <= lfsr_cand;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		victim_q <= victim_of(lfsr_cand);
		if (accept) begin
			tag_q   <= TAG_W'(address >> TAG_LSB);
			set_q   <= address[OFFSET_BITS +: INDEX_W];
			mod_x_q <= address[ADDRESS_BITS-1:OFFSET_BITS];
		end
		if (state_q == ST_MOD) begin
			quo_q <= quo_nxt;
		end
		if (state_q == ST_READ) begin
			set_q <= set_red;
		end
		if (accept && command == CMD_CLEAR) begin
			hit_q     <= 1'b0;
			way_q     <= '0;
			evicted_q <= 1'b0;
		end
		if (state_q == ST_LOOKUP) begin
			hit_q     <= look.hit;
			way_q     <= look.way;
			evicted_q <= look.evicted;
		end
	end

endmodule

>>> hw/rtl/sacr_checker.sv
// Port-level checker for the tag store top level, bound to it.
module sacr_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                command,
	input logic                                done,
	input logic                                hit,
	input logic                                evicted,
	input logic [sacr_pkg::COUNT_W-1:0]        hit_total,
	input logic [sacr_pkg::COUNT_W-1:0]        miss_total
);
	import sacr_pkg::*;

	// A clear answers at once with everything zeroed
	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == CMD_CLEAR) |=>
		(done && !hit && !evicted && hit_total == '0 && miss_total == '0))
		else $error("clear result not zero");

	// Every accepted word keeps the block busy the next cycle
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("not busy after accepting a word");

	// Results in consecutive cycles only when the second answers a clear
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done || (!hit && !evicted && hit_total == '0 && miss_total == '0)))
		else $error("results in consecutive cycles");

	// A hit never evicts and is counted
	a_hit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> (!evicted && hit_total != '0))
		else $error("hit evicted or not counted");

	// An eviction is a counted miss
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && evicted) |-> (!hit && miss_total != '0))
		else $error("eviction without a counted miss");

endmodule

bind set_assoc_cache_random_replace_unit sacr_checker u_sacr_checker (.*);

>>> bench/tb_set_assoc_cache_random_replace_unit.sv
// Self-checking 4-way tag store bench: directed, seed, drain, random and back-to-back tests.
module tb_set_assoc_cache_random_replace_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import sacr_pkg::*;

	// One lookup result as the block reports it
	typedef struct packed {
		logic                 hit;
		logic [WAY_OUT_W-1:0] way;
		logic                 evicted;
		logic [COUNT_W-1:0]   hit_total;
		logic [COUNT_W-1:0]   miss_total;
	} lookup_outcome_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    command;
	logic [ADDRESS_BITS-1:0] address;
	logic                    done;
	logic                    hit;
	logic [WAY_OUT_W-1:0]    way;
	logic                    evicted;
	logic [COUNT_W-1:0]      hit_total;
	logic [COUNT_W-1:0]      miss_total;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [SEED_W-1:0]       cfg_data;

	// Shadow copy of the tag store
	logic [NUM_WAYS-1:0] shadow_valid [NUM_SETS];
	logic [TAG_W-1:0]    shadow_tag   [NUM_SETS][NUM_WAYS];
	logic [COUNT_W-1:0]  shadow_hits;
	logic [COUNT_W-1:0]  shadow_misses;
	logic [LFSR_W-1:0]   shadow_lfsr;
	logic [SEED_W-1:0]   shadow_seed;

	lookup_outcome_t expected_lookups [$];
	int unsigned     fault_count;
	bit              gaps_on;

	set_assoc_cache_random_replace_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.address    (address),
		.done       (done),
		.hit        (hit),
		.way        (way),
		.evicted    (evicted),
		.hit_total  (hit_total),
		.miss_total (miss_total),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Work out the result of one accepted word and update the shadow state
	function automatic void predict_lookup(cmd_t cmd, logic [ADDRESS_BITS-1:0] addr);
		lookup_outcome_t     o;
		logic [INDEX_W-1:0]  set_idx;
		logic [TAG_W-1:0]    tag;
		logic [NUM_WAYS-1:0] v;
		bit                  found;
		bit                  placed;
		int                  victim;
		o = '0;
		found = 1'b0;
		placed = 1'b0;
		victim = 0;
		if (cmd == CMD_CLEAR) begin
			foreach (shadow_valid[i]) shadow_valid[i] = '0;
			shadow_hits = '0;
			shadow_misses = '0;
			// a zero seed would lock the LFSR
			shadow_lfsr = (shadow_seed == '0) ? LFSR_W'(1) : shadow_seed;
			expected_lookups.push_back(o);
			return;
		end
		set_idx = INDEX_W'((addr >> OFFSET_BITS) % ADDRESS_BITS'(NUM_SETS));
		tag = TAG_W'(addr >> TAG_LSB);
		v = shadow_valid[set_idx];
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (!found && v[w] && shadow_tag[set_idx][w] == tag) begin
				found = 1'b1;
				victim = w;
			end
		end
		if (found) begin
			o.hit = 1'b1;
			if (shadow_hits != COUNT_MAX) shadow_hits = shadow_hits + 1'b1;
		end else begin
			if (shadow_misses != COUNT_MAX) shadow_misses = shadow_misses + 1'b1;
			// lowest empty way first
			for (int w = 0; w < NUM_WAYS; w++) begin
				if (!placed && !v[w]) begin
					placed = 1'b1;
					victim = w;
				end
			end
			// set full: LFSR steps once and picks the victim
			if (!placed) begin
				shadow_lfsr = {1'b0, shadow_lfsr[LFSR_W-1:1]} ^
					(shadow_lfsr[0] ? LFSR_TAPS : '0);
				victim = int'(shadow_lfsr) % NUM_WAYS;
				o.evicted = 1'b1;
			end
			shadow_tag[set_idx][victim] = tag;
			shadow_valid[set_idx][victim] = 1'b1;
		end
		o.way = WAY_OUT_W'(victim);
		o.hit_total = shadow_hits;
		o.miss_total = shadow_misses;
		expected_lookups.push_back(o);
	endfunction

	task automatic check_field(string fname, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
			fault_count++;
		end
	endtask

	// Result checker: every strobed word against the oldest expectation
	always @(posedge clk) begin
		lookup_outcome_t want;
		if (done === 1'b1) begin
			if (expected_lookups.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual hit=%0b way=%0d",
					$time, hit, way);
				fault_count++;
			end else begin
				want = expected_lookups.pop_front();
				check_field("hit", COUNT_W'(want.hit), COUNT_W'(hit));
				check_field("way", COUNT_W'(want.way), COUNT_W'(way));
				check_field("evicted", COUNT_W'(want.evicted), COUNT_W'(evicted));
				check_field("hit_total", want.hit_total, hit_total);
				check_field("miss_total", want.miss_total, miss_total);
			end
		end
	end

	// Present one word and hold it until accepted; start stays high afterwards
	task automatic send_word(cmd_t cmd, logic [ADDRESS_BITS-1:0] addr);
		start <= 1'b1;
		command <= cmd;
		address <= addr;
		do @(posedge clk); while (busy);
		predict_lookup(cmd, addr);
	endtask

	task automatic pause(int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic maybe_gap();
		if (gaps_on && $urandom_range(0, 3) == 0) pause($urandom_range(1, 9));
	endtask

	// Sender holds off until every result is in and the block is idle
	task automatic wait_quiet();
		start <= 1'b0;
		@(posedge clk);
		while (expected_lookups.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_seed(logic [SEED_W-1:0] seed);
		wait_quiet();
		cfg_valid <= 1'b1;
		cfg_data <= seed;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_seed = seed;
	endtask

	function automatic logic [ADDRESS_BITS-1:0] line_addr(logic [TAG_W-1:0] tag,
			logic [INDEX_W-1:0] set_idx);
		return {tag, set_idx, OFFSET_BITS'($urandom)};
	endfunction

	// Fills, hits, offset aliasing, evictions from the reset LFSR, clear
	task automatic test_directed();
		send_word(CMD_ACCESS, 32'h0000_0000);
		send_word(CMD_ACCESS, 32'h0000_0003);
		send_word(CMD_ACCESS, 32'hFFFF_FFFF);
		send_word(CMD_ACCESS, 32'hFFFF_FFFC);
		send_word(CMD_ACCESS, 32'hAAAA_AAAA);
		send_word(CMD_ACCESS, 32'h5555_5555);
		for (int t = 1; t < 4; t++) send_word(CMD_ACCESS, line_addr(TAG_W'(t), '0));
		send_word(CMD_ACCESS, line_addr('1, '0));
		send_word(CMD_ACCESS, line_addr(16'h8000, '0));
		send_word(CMD_CLEAR, 32'hFFFF_FFFF);
		send_word(CMD_ACCESS, 32'h0000_0000);
		send_word(CMD_ACCESS, 32'hFFFF_FFFF);
	endtask

	// Seed extremes, zero seed among them, each driving a few evictions
	task automatic test_seed_extremes();
		logic [SEED_W-1:0] seeds [2];
		seeds[0] = '0;
		seeds[1] = '1;
		foreach (seeds[s]) begin
			load_seed(seeds[s]);
			send_word(CMD_CLEAR, '0);
			for (int t = 0; t < 6; t++)
				send_word(CMD_ACCESS, line_addr(TAG_W'(t * 16'h1111), INDEX_W'(5)));
			send_word(CMD_ACCESS, line_addr(16'h5555, INDEX_W'(5)));
		end
	endtask

	// Random phases: fresh seed, clear, then mostly traffic on a few sets
	task automatic test_random_traffic(int phases, int words);
		logic [INDEX_W-1:0] set_pool [4];
		logic [TAG_W-1:0]   tag_pool [6];
		int                 roll;
		for (int p = 0; p < phases; p++) begin
			load_seed(SEED_W'($urandom));
			gaps_on = ($urandom_range(0, 2) != 0);
			foreach (set_pool[i]) set_pool[i] = INDEX_W'($urandom);
			foreach (tag_pool[i]) tag_pool[i] = TAG_W'($urandom);
			send_word(CMD_CLEAR, ADDRESS_BITS'($urandom));
			for (int i = 0; i < words; i++) begin
				maybe_gap();
				roll = $urandom_range(0, 99);
				if (roll == 0)
					send_word(CMD_CLEAR, ADDRESS_BITS'($urandom));
				else if (roll < 88)
					send_word(CMD_ACCESS, line_addr(tag_pool[$urandom_range(0, 5)],
						set_pool[$urandom_range(0, 3)]));
				else
					send_word(CMD_ACCESS, ADDRESS_BITS'($urandom));
			end
		end
	endtask

	// Sender stops until the block has answered everything, then resumes
	task automatic test_drain_pause();
		for (int i = 0; i < 5; i++) send_word(CMD_ACCESS, line_addr(TAG_W'(i), INDEX_W'(9)));
		wait_quiet();
		for (int i = 0; i < 5; i++) send_word(CMD_ACCESS, line_addr(TAG_W'(4 - i), INDEX_W'(9)));
	endtask

	// Closing stretch with no idling at all
	task automatic test_back_to_back(int words);
		logic [INDEX_W-1:0] set_a;
		set_a = INDEX_W'($urandom);
		gaps_on = 1'b0;
		for (int i = 0; i < words; i++)
			send_word(CMD_ACCESS, line_addr(TAG_W'($urandom_range(0, 7)),
				set_a + INDEX_W'($urandom_range(0, 1))));
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		command = 1'b0;
		address = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		fault_count = 0;
		gaps_on = 1'b1;
		foreach (shadow_valid[i]) shadow_valid[i] = '0;
		shadow_hits = '0;
		shadow_misses = '0;
		shadow_lfsr = LFSR_W'(1);
		shadow_seed = SEED_W'(1);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_seed_extremes();
		test_drain_pause();
		test_random_traffic(8, 118);
		test_back_to_back(150);

		start <= 1'b0;
		while (expected_lookups.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fault_count == 0 && expected_lookups.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#40ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
